// File: design/assert_macros.svh
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MTEP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define MTEP_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define MTEP_ASSERT(lbl, clk, rst_n, prop)
`define MTEP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/mtep_pkg.sv
// Package with types, codes and helpers of the MIDI track event parser.
`timescale 1ns / 1ps
package mtep_pkg;
	localparam int NAME_LIMIT_DEF = 256;
	localparam int QDEPTH = 4;
	localparam int DIV_STEPS = 12;

	localparam logic [3:0] KIND_MSG2    = 4'd0;
	localparam logic [3:0] KIND_MSG1    = 4'd1;
	localparam logic [3:0] KIND_BUS     = 4'd2;
	localparam logic [3:0] KIND_CHANNEL = 4'd3;
	localparam logic [3:0] KIND_TIMESIG = 4'd4;
	localparam logic [3:0] KIND_TRIGGER = 4'd5;
	localparam logic [3:0] KIND_END     = 4'd6;
	localparam logic [3:0] KIND_NAME    = 4'd7;
	localparam logic [3:0] KIND_SEQNUM  = 4'd8;
	localparam logic [3:0] KIND_ERROR   = 4'd9;

	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] META_SEQNUM  = 8'h00;
	localparam logic [7:0] META_NAME    = 8'h03;
	localparam logic [7:0] META_END     = 8'h2F;
	localparam logic [7:0] META_PROP    = 8'h7F;

	localparam logic [2:0] CFG_FILE_PPQN   = 3'd0;
	localparam logic [2:0] CFG_TARGET_PPQN = 3'd1;
	localparam logic [2:0] CFG_TAG_BUS     = 3'd2;
	localparam logic [2:0] CFG_TAG_CHAN    = 3'd3;
	localparam logic [2:0] CFG_TAG_TSIG    = 3'd4;
	localparam logic [2:0] CFG_TAG_TRIG_O  = 3'd5;
	localparam logic [2:0] CFG_TAG_TRIG_N  = 3'd6;

	typedef enum logic [17:0] {
		PH_DELTA     = 18'h00001,
		PH_STATUS    = 18'h00002,
		PH_D1_TWO    = 18'h00004,
		PH_D2        = 18'h00008,
		PH_D1_ONE    = 18'h00010,
		PH_META_TYPE = 18'h00020,
		PH_META_LEN  = 18'h00040,
		PH_SYSEX_LEN = 18'h00080,
		PH_SKIP      = 18'h00100,
		PH_NAME      = 18'h00200,
		PH_SEQ       = 18'h00400,
		PH_PTAG      = 18'h00800,
		PH_PBUS      = 18'h01000,
		PH_PCHAN     = 18'h02000,
		PH_PTSIG     = 18'h04000,
		PH_TRIG_OLD  = 18'h08000,
		PH_TRIG_NEW  = 18'h10000,
		PH_HALT      = 18'h20000
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_MUL  = 3'b010,
		BK_DIV  = 3'b100
	} back_state_t;

	typedef struct packed {
		logic [31:0] bus;
		logic [31:0] chan;
		logic [31:0] tsig;
		logic [31:0] trig_old;
		logic [31:0] trig_new;
	} tags_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] need;
		phase_t     ph;
	} pdisp_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] rtime;
		logic [7:0]  status;
		logic [3:0]  chan;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic        last;
		logic        add_one;
	} ev_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// The first matching tag in register order wins.
	function automatic pdisp_t prop_sel(input logic [31:0] tag, input tags_t t);
		pdisp_t r;
		r.hit = 1'b1;
		r.need = 4'd0;
		r.ph = PH_SKIP;
		if (tag == t.bus) begin
			r.need = 4'd1;
			r.ph = PH_PBUS;
		end else if (tag == t.chan) begin
			r.need = 4'd1;
			r.ph = PH_PCHAN;
		end else if (tag == t.tsig) begin
			r.need = 4'd2;
			r.ph = PH_PTSIG;
		end else if (tag == t.trig_old) begin
			r.need = 4'd8;
			r.ph = PH_TRIG_OLD;
		end else if (tag == t.trig_new) begin
			r.need = 4'd12;
			r.ph = PH_TRIG_NEW;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction
endpackage

// File: design/mtep_if.sv
// Channel interfaces for track bytes and parsed events.
`timescale 1ns / 1ps
interface mtep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_byte;
	logic       track_start;
	modport source (output valid, output track_byte, output track_start, input ready);
	modport sink (input valid, input track_byte, input track_start, output ready);
endinterface

interface mtep_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [31:0] timestamp;
	logic [7:0]  status_code;
	logic [3:0]  channel_number;
	logic [7:0]  data_first;
	logic [7:0]  data_second;
	logic [31:0] value_a;
	logic [31:0] value_b;
	logic [31:0] value_c;
	logic        last_of_track;
	modport source (output valid, output kind, output timestamp, output status_code,
		output channel_number, output data_first, output data_second, output value_a,
		output value_b, output value_c, output last_of_track, input ready);
	modport sink (input valid, input kind, input timestamp, input status_code,
		input channel_number, input data_first, input data_second, input value_a,
		input value_b, input value_c, input last_of_track, output ready);
endinterface

// File: design/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser with its configuration registers.
//  channel    direction  transaction
//  track_in   in         one track byte with its start-of-track flag
//  event_out  out        one parsed event with its scaled timestamp
// The parser takes one byte per cycle while its queue has room.
// Each event passes through the scaler: a multiply by the target rate, then a
// four-bit-per-cycle divider by the file rate.
// A finished event waits in the output register while the next one is scaled.
// Reset is asynchronous; all control state clears at once, with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module midi_track_event_parser_core #(
	parameter int NAME_LIMIT = mtep_pkg::NAME_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mtep_in_if.sink     track_in,
	mtep_out_if.source  event_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [15:0] file_ppqn_q, target_ppqn_q;
	mtep_pkg::tags_t tags_q;
	mtep_pkg::q_stat_t qstat;
	mtep_pkg::ev_entry_t push_data, pop_data;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_ppqn_q <= 16'd192;
			target_ppqn_q <= 16'd192;
			tags_q.bus <= 32'h2424_0001;
			tags_q.chan <= 32'h2424_0002;
			tags_q.tsig <= 32'h2424_0006;
			tags_q.trig_old <= 32'h2424_0004;
			tags_q.trig_new <= 32'h2424_0008;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtep_pkg::CFG_FILE_PPQN: file_ppqn_q <= cfg_data[15:0];
				mtep_pkg::CFG_TARGET_PPQN: target_ppqn_q <= cfg_data[15:0];
				mtep_pkg::CFG_TAG_BUS: tags_q.bus <= cfg_data;
				mtep_pkg::CFG_TAG_CHAN: tags_q.chan <= cfg_data;
				mtep_pkg::CFG_TAG_TSIG: tags_q.tsig <= cfg_data;
				mtep_pkg::CFG_TAG_TRIG_O: tags_q.trig_old <= cfg_data;
				mtep_pkg::CFG_TAG_TRIG_N: tags_q.trig_new <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mtep_front #(.NAME_LIMIT(NAME_LIMIT)) u_front (
		.clk(clk), .arst_n(arst_n), .track_in(track_in), .tags(tags_q),
		.qstat(qstat), .push(push), .push_data(push_data)
	);

	mtep_queue #(.DEPTH(mtep_pkg::QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .pop_data(pop_data), .stat(qstat)
	);

	mtep_back u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .pop(pop), .pop_data(pop_data),
		.file_ppqn(file_ppqn_q), .target_ppqn(target_ppqn_q), .event_out(event_out)
	);

	`MTEP_NEVER(a_queue_state, clk, arst_n, qstat.full && qstat.empty)
	`MTEP_NEVER(a_no_pop_empty, clk, arst_n, pop && qstat.empty)
	`MTEP_ASSERT(a_last_kind, clk, arst_n, (event_out.valid && event_out.last_of_track) |-> (event_out.kind == mtep_pkg::KIND_END || event_out.kind == mtep_pkg::KIND_ERROR))
endmodule

// File: design/mtep_front.sv
// Byte parser: decodes the track stream and queues raw event records.
`timescale 1ns / 1ps
module mtep_front #(
	parameter int NAME_LIMIT = mtep_pkg::NAME_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	mtep_in_if.sink             track_in,
	input  mtep_pkg::tags_t     tags,
	input  mtep_pkg::q_stat_t   qstat,
	output logic                push,
	output mtep_pkg::ev_entry_t push_data
);
	localparam logic [31:0] NAME_LIM = 32'(NAME_LIMIT);

	mtep_pkg::phase_t phase_q;
	logic [7:0]  status_q;
	logic [31:0] vacc_q;
	logic [31:0] ldelta_q;
	logic [31:0] rtime_q;
	logic [7:0]  mtype_q;
	logic [31:0] rem_q;
	logic [31:0] ptag_q;
	logic [3:0]  bcnt_q;
	logic [31:0] w0_q, w1_q, w2_q;
	logic [7:0]  held_q;

	mtep_pkg::phase_t ph;
	logic [7:0]  st, s, b, hd, mt;
	logic [31:0] va, ld, rt, rem, tag, w0, w1, w2, len, n;
	logic [3:0]  bc;
	logic        em, run_body, accept;
	mtep_pkg::ev_entry_t e;
	mtep_pkg::pdisp_t pd;

	assign track_in.ready = !qstat.full;
	assign accept = track_in.valid && track_in.ready;
	assign push = accept && em;
	assign push_data = e;

	always_comb begin
		ph = phase_q; st = status_q; va = vacc_q; ld = ldelta_q; rt = rtime_q;
		mt = mtype_q; rem = rem_q; tag = ptag_q; bc = bcnt_q;
		w0 = w0_q; w1 = w1_q; w2 = w2_q; hd = held_q;
		b = track_in.track_byte;
		em = 1'b0; run_body = 1'b0; s = st; len = '0; n = '0;
		pd = mtep_pkg::prop_sel(tag, tags);
		e = '0;
		if (track_in.track_start) begin
			rt = '0; ld = '0; st = '0; tag = '0; rem = '0; bc = '0;
			ph = mtep_pkg::PH_DELTA; va = '0;
		end
		if (ph == mtep_pkg::PH_DELTA) begin
			va = {va[24:0], b[6:0]};
			if (!b[7]) begin
				ld = va;
				rt = rt + va;
				va = '0;
				ph = mtep_pkg::PH_STATUS;
			end
		end else if (ph == mtep_pkg::PH_STATUS) begin
			if (b[7]) st = b;
			run_body = !b[7];
			case (st[7:4])
				4'h8, 4'h9, 4'hA, 4'hB, 4'hE: ph = mtep_pkg::PH_D1_TWO;
				4'hC, 4'hD: ph = mtep_pkg::PH_D1_ONE;
				default: begin
					if (st == mtep_pkg::STATUS_META) begin
						ph = mtep_pkg::PH_META_TYPE;
					end else if (st == mtep_pkg::STATUS_SYSEX) begin
						va = '0;
						ph = mtep_pkg::PH_SYSEX_LEN;
					end else begin
						ph = mtep_pkg::PH_HALT;
						run_body = 1'b0;
						em = 1'b1;
						e.kind = mtep_pkg::KIND_ERROR;
						e.status = st;
						e.last = 1'b1;
					end
				end
			endcase
		end else begin
			run_body = 1'b1;
		end
		if (run_body) begin
			unique case (ph)
				mtep_pkg::PH_D1_TWO: begin
					hd = b;
					ph = mtep_pkg::PH_D2;
				end
				mtep_pkg::PH_D2: begin
					s = st;
					if (s[7:4] == 4'h9 && b == 8'h00) s = {4'h8, s[3:0]};
					ph = mtep_pkg::PH_DELTA; va = '0;
					em = 1'b1; e.kind = mtep_pkg::KIND_MSG2; e.status = s;
					e.chan = s[3:0]; e.d1 = hd; e.d2 = b;
				end
				mtep_pkg::PH_D1_ONE: begin
					ph = mtep_pkg::PH_DELTA; va = '0;
					em = 1'b1; e.kind = mtep_pkg::KIND_MSG1; e.status = st;
					e.chan = st[3:0]; e.d1 = b;
				end
				mtep_pkg::PH_META_TYPE: begin
					mt = b; va = '0;
					ph = mtep_pkg::PH_META_LEN;
				end
				mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
					va = {va[24:0], b[6:0]};
					if (!b[7]) begin
						if (ph == mtep_pkg::PH_SYSEX_LEN) begin
							rem = va; va = '0;
							ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
						end else begin
							len = va; rem = len; va = '0;
							if (mt == mtep_pkg::META_PROP) begin
								if (len > 32'd4) begin
									bc = '0; w0 = '0; ph = mtep_pkg::PH_PTAG;
								end else begin
									bc = '0;
									if (pd.hit && rem >= 32'(pd.need)) ph = pd.ph;
									else ph = (rem == '0) ? mtep_pkg::PH_DELTA
										: mtep_pkg::PH_SKIP;
								end
							end else if (mt == mtep_pkg::META_END) begin
								ph = mtep_pkg::PH_HALT;
								em = 1'b1; e.kind = mtep_pkg::KIND_END;
								e.status = mtep_pkg::STATUS_META;
								e.add_one = (ld == '0); e.last = 1'b1;
							end else if (mt == mtep_pkg::META_NAME) begin
								n = (len < NAME_LIM) ? len : NAME_LIM;
								rem = len - n;
								if (n == '0) begin
									ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
								end else begin
									va = n; ph = mtep_pkg::PH_NAME;
								end
							end else if (mt == mtep_pkg::META_SEQNUM) begin
								if (len == '0) begin
									ph = mtep_pkg::PH_DELTA;
									em = 1'b1; e.kind = mtep_pkg::KIND_SEQNUM;
									e.status = mtep_pkg::STATUS_META;
								end else begin
									bc = '0;
									if (rem >= 32'd2) ph = mtep_pkg::PH_SEQ;
									else ph = mtep_pkg::PH_SKIP;
								end
							end else begin
								ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
							end
						end
					end
				end
				mtep_pkg::PH_SKIP: begin
					if (rem != '0) rem = rem - 32'd1;
					if (rem == '0) begin
						ph = mtep_pkg::PH_DELTA; va = '0;
					end
				end
				mtep_pkg::PH_NAME: begin
					va = va - 32'd1;
					if (va == '0) ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					em = 1'b1; e.kind = mtep_pkg::KIND_NAME;
					e.status = mtep_pkg::STATUS_META; e.d1 = b;
				end
				mtep_pkg::PH_SEQ, mtep_pkg::PH_PTSIG: begin
					rem = rem - 32'd1;
					if (bc == '0) begin
						hd = b; bc = 4'd1;
					end else begin
						ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
						va = '0;
						em = 1'b1; e.status = mtep_pkg::STATUS_META;
						if (phase_q == mtep_pkg::PH_PTSIG) begin
							e.kind = mtep_pkg::KIND_TIMESIG; e.d1 = hd; e.d2 = b;
						end else begin
							e.kind = mtep_pkg::KIND_SEQNUM; e.a = {16'h0, hd, b};
						end
					end
				end
				mtep_pkg::PH_PTAG: begin
					rem = rem - 32'd1;
					w0 = {w0[23:0], b};
					bc = bc + 4'd1;
					if (bc >= 4'd4) begin
						tag = w0;
						pd = mtep_pkg::prop_sel(tag, tags);
						bc = '0;
						if (pd.hit && rem >= 32'(pd.need)) ph = pd.ph;
						else ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					end
				end
				mtep_pkg::PH_PBUS: begin
					rem = rem - 32'd1;
					ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					va = '0;
					em = 1'b1; e.kind = mtep_pkg::KIND_BUS;
					e.status = mtep_pkg::STATUS_META; e.d1 = b;
				end
				mtep_pkg::PH_PCHAN: begin
					rem = rem - 32'd1;
					ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					va = '0;
					em = 1'b1; e.kind = mtep_pkg::KIND_CHANNEL;
					e.status = mtep_pkg::STATUS_META; e.chan = b[3:0];
				end
				mtep_pkg::PH_TRIG_OLD, mtep_pkg::PH_TRIG_NEW: begin
					rem = rem - 32'd1;
					case (bc[3:2])
						2'd0: w0 = (bc[1:0] == 2'd0) ? {24'h0, b} : {w0[23:0], b};
						2'd1: w1 = (bc[1:0] == 2'd0) ? {24'h0, b} : {w1[23:0], b};
						default: w2 = (bc[1:0] == 2'd0) ? {24'h0, b} : {w2[23:0], b};
					endcase
					bc = bc + 4'd1;
					if ((ph == mtep_pkg::PH_TRIG_OLD && bc >= 4'd8)
						|| (ph == mtep_pkg::PH_TRIG_NEW && bc >= 4'd12)) begin
						em = 1'b1; e.kind = mtep_pkg::KIND_TRIGGER;
						e.status = mtep_pkg::STATUS_META; e.a = w0;
						if (ph == mtep_pkg::PH_TRIG_OLD) begin
							e.b = w1 - w0;
						end else begin
							e.b = w1 - w0 + 32'd1; e.c = w2;
						end
						if (rem < ((ph == mtep_pkg::PH_TRIG_OLD) ? 32'd8 : 32'd12)) begin
							ph = (rem == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
							va = '0;
						end
						bc = '0;
					end
				end
				default: begin
				end
			endcase
		end
		e.rtime = rt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_DELTA;
			status_q <= '0;
			vacc_q <= '0;
			ldelta_q <= '0;
			rtime_q <= '0;
			mtype_q <= '0;
			rem_q <= '0;
			ptag_q <= '0;
			bcnt_q <= '0;
		end else if (accept) begin
			phase_q <= ph;
			status_q <= st;
			vacc_q <= va;
			ldelta_q <= ld;
			rtime_q <= rt;
			mtype_q <= mt;
			rem_q <= rem;
			ptag_q <= tag;
			bcnt_q <= bc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w0_q <= w0;
			w1_q <= w1;
			w2_q <= w2;
			held_q <= hd;
		end
	end
endmodule

// File: design/mtep_queue.sv
// Short queue of raw event records between the parser and the time scaler.
`timescale 1ns / 1ps
module mtep_queue #(
	parameter int DEPTH = mtep_pkg::QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mtep_pkg::ev_entry_t push_data,
	input  logic                pop,
	output mtep_pkg::ev_entry_t pop_data,
	output mtep_pkg::q_stat_t   stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mtep_pkg::ev_entry_t slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign stat.full = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: design/mtep_back.sv
// Time scaler: multiplies by the target rate, divides by the file rate, drives events.
`timescale 1ns / 1ps
module mtep_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mtep_pkg::q_stat_t   qstat,
	output logic                pop,
	input  mtep_pkg::ev_entry_t pop_data,
	input  logic [15:0]         file_ppqn,
	input  logic [15:0]         target_ppqn,
	mtep_out_if.source          event_out
);
	mtep_pkg::back_state_t state_q;
	mtep_pkg::ev_entry_t   ent_q, res_q, res;
	logic [47:0] dvd_q, d;
	logic [16:0] rem_q, r;
	logic [3:0]  cnt_q;
	logic [31:0] ts_q, ts;
	logic        ovalid_q, done, free;

	assign pop = (state_q == mtep_pkg::BK_IDLE) && !qstat.empty;
	assign free = !ovalid_q || event_out.ready;
	assign done = (state_q == mtep_pkg::BK_DIV) && (cnt_q == 4'(mtep_pkg::DIV_STEPS));

	// Four restoring division steps per cycle.
	always_comb begin
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[15:0], d[47]};
			d = {d[46:0], 1'b0};
			if (r >= {1'b0, file_ppqn}) begin
				r = r - {1'b0, file_ppqn};
				d[0] = 1'b1;
			end
		end
		ts = (file_ppqn == '0) ? 32'hFFFF_FFFF : dvd_q[31:0];
		res = ent_q;
		if (ent_q.add_one) res.a = ts + 32'd1;
		else if (ent_q.kind == mtep_pkg::KIND_END) res.a = ts;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtep_pkg::BK_IDLE;
			ovalid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				mtep_pkg::BK_IDLE: begin
					if (!qstat.empty) state_q <= mtep_pkg::BK_MUL;
				end
				mtep_pkg::BK_MUL: begin
					cnt_q <= '0;
					state_q <= mtep_pkg::BK_DIV;
				end
				mtep_pkg::BK_DIV: begin
					if (!done) begin
						cnt_q <= cnt_q + 4'd1;
					end else if (free) begin
						state_q <= mtep_pkg::BK_IDLE;
					end
				end
				default: state_q <= mtep_pkg::BK_IDLE;
			endcase
			if (done && free) ovalid_q <= 1'b1;
			else if (event_out.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= pop_data;
		if (state_q == mtep_pkg::BK_MUL) begin
			dvd_q <= 48'(ent_q.rtime * target_ppqn);
			rem_q <= '0;
		end else if (state_q == mtep_pkg::BK_DIV && !done) begin
			dvd_q <= d;
			rem_q <= r;
		end
		if (done && free) begin
			res_q <= res;
			ts_q <= ts;
		end
	end

	assign event_out.valid = ovalid_q;
	assign event_out.kind = res_q.kind;
	assign event_out.timestamp = ts_q;
	assign event_out.status_code = res_q.status;
	assign event_out.channel_number = res_q.chan;
	assign event_out.data_first = res_q.d1;
	assign event_out.data_second = res_q.d2;
	assign event_out.value_a = res_q.a;
	assign event_out.value_b = res_q.b;
	assign event_out.value_c = res_q.c;
	assign event_out.last_of_track = res_q.last;
endmodule

// File: tb/tb_pkg.sv
// Shared constants for the parser testbench.
`timescale 1ns / 1ps
package tb_pkg;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_PROGRAM  = 8'hC0;
endpackage

// File: tb/tb_top.sv
// Self-checking testbench of the MIDI track event parser with its own event predictor.
`timescale 1ns / 1ps
module tb_top;
	import mtep_pkg::*;
	import tb_pkg::*;

	typedef struct packed {
		logic [7:0] tbyte;
		logic       tstart;
	} track_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] ts;
		logic [7:0]  st;
		logic [3:0]  ch;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic        last;
	} parsed_event_t;

	typedef enum int {
		P_DELTA, P_STATUS, P_D1_TWO, P_D2, P_D1_ONE, P_META_TYPE, P_META_LEN,
		P_SYSEX_LEN, P_SKIP, P_NAME, P_SEQ, P_PTAG, P_PBUS, P_PCHAN, P_PTSIG,
		P_TRIG_OLD, P_TRIG_NEW, P_HALT
	} pred_phase_t;

	localparam int LIMIT_CYCLES = 900000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	mtep_in_if track_in ();
	mtep_out_if event_out ();

	midi_track_event_parser_core u_dut (
		.clk(clk), .arst_n(arst_n), .track_in(track_in), .event_out(event_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	track_item_t pending_bytes[$];
	parsed_event_t expected_events[$];
	int errors;
	bit byte_accepted;
	bit stim_done;
	int send_wait;
	int recv_wait;
	int hold_off;
	bit pause_sender;
	longint cycle_count;

	// Predictor state.
	logic [31:0] p_file, p_target;
	logic [31:0] p_tags[5];
	pred_phase_t ph;
	logic [7:0] cur_status, meta_t, held;
	logic [31:0] vacc, last_dt, run_time, remaining, ptag;
	logic [31:0] words[3];
	int unsigned bcount;

	function automatic logic [31:0] scaled_time();
		logic [63:0] prod;
		prod = run_time * {32'd0, p_target};
		if (p_file == 0)
			return 32'hFFFF_FFFF;
		return 32'(prod / p_file);
	endfunction

	task automatic push_event(input logic [3:0] k, input logic [7:0] s, input logic [3:0] c,
		input logic [7:0] x1, input logic [7:0] x2, input logic [31:0] va,
		input logic [31:0] vb, input logic [31:0] vc, input logic l);
		parsed_event_t e;
		e = '{k, scaled_time(), s, c, x1, x2, va, vb, vc, l};
		expected_events.push_back(e);
	endtask

	task automatic to_delta();
		ph = P_DELTA;
		vacc = 0;
	endtask

	task automatic to_skip();
		if (remaining == 0)
			to_delta();
		else
			ph = P_SKIP;
	endtask

	task automatic require(input int unsigned n, input pred_phase_t nxt);
		bcount = 0;
		if (remaining >= n)
			ph = nxt;
		else
			to_skip();
	endtask

	task automatic tag_dispatch();
		if (ptag == p_tags[0])
			require(1, P_PBUS);
		else if (ptag == p_tags[1])
			require(1, P_PCHAN);
		else if (ptag == p_tags[2])
			require(2, P_PTSIG);
		else if (ptag == p_tags[3])
			require(8, P_TRIG_OLD);
		else if (ptag == p_tags[4])
			require(12, P_TRIG_NEW);
		else
			to_skip();
	endtask

	task automatic meta_start();
		logic [31:0] len, n;
		len = vacc;
		remaining = len;
		vacc = 0;
		case (meta_t)
			META_PROP: begin
				if (len > 4) begin
					bcount = 0;
					words[0] = 0;
					ph = P_PTAG;
				end else
					tag_dispatch();
			end
			META_END: begin
				ph = P_HALT;
				push_event(KIND_END, STATUS_META, 0, 0, 0,
					scaled_time() + (last_dt == 0 ? 32'd1 : 32'd0), 0, 0, 1'b1);
			end
			META_NAME: begin
				n = len < 256 ? len : 32'd256;
				remaining = len - n;
				if (n == 0)
					to_skip();
				else begin
					vacc = n;
					ph = P_NAME;
				end
			end
			META_SEQNUM: begin
				if (len == 0) begin
					to_delta();
					push_event(KIND_SEQNUM, STATUS_META, 0, 0, 0, 0, 0, 0, 1'b0);
				end else
					require(2, P_SEQ);
			end
			default: to_skip();
		endcase
	endtask

	task automatic body(input logic [7:0] b);
		logic [7:0] s;
		int unsigned idx;
		logic [31:0] on, off;
		case (ph)
			P_D1_TWO: begin
				held = b;
				ph = P_D2;
			end
			P_D2: begin
				s = cur_status;
				if (s[7:4] == ST_NOTE_ON[7:4] && b == 0)
					s = ST_NOTE_OFF | {4'd0, s[3:0]};
				to_delta();
				push_event(KIND_MSG2, s, s[3:0], held, b, 0, 0, 0, 1'b0);
			end
			P_D1_ONE: begin
				to_delta();
				push_event(KIND_MSG1, cur_status, cur_status[3:0], b, 0, 0, 0, 0, 1'b0);
			end
			P_META_TYPE: begin
				meta_t = b;
				vacc = 0;
				ph = P_META_LEN;
			end
			P_META_LEN, P_SYSEX_LEN: begin
				vacc = (vacc << 7) | b[6:0];
				if (!b[7]) begin
					if (ph == P_META_LEN)
						meta_start();
					else begin
						remaining = vacc;
						vacc = 0;
						to_skip();
					end
				end
			end
			P_SKIP: begin
				if (remaining > 0)
					remaining--;
				if (remaining == 0)
					to_delta();
			end
			P_NAME: begin
				vacc--;
				if (vacc == 0)
					to_skip();
				push_event(KIND_NAME, STATUS_META, 0, b, 0, 0, 0, 0, 1'b0);
			end
			P_SEQ: begin
				remaining--;
				if (bcount == 0) begin
					held = b;
					bcount = 1;
				end else begin
					to_skip();
					push_event(KIND_SEQNUM, STATUS_META, 0, 0, 0, {16'd0, held, b}, 0, 0,
						1'b0);
				end
			end
			P_PTAG: begin
				remaining--;
				words[0] = (words[0] << 8) | b;
				bcount++;
				if (bcount >= 4) begin
					ptag = words[0];
					tag_dispatch();
				end
			end
			P_PBUS: begin
				remaining--;
				to_skip();
				push_event(KIND_BUS, STATUS_META, 0, b, 0, 0, 0, 0, 1'b0);
			end
			P_PCHAN: begin
				remaining--;
				to_skip();
				push_event(KIND_CHANNEL, STATUS_META, b[3:0], 0, 0, 0, 0, 0, 1'b0);
			end
			P_PTSIG: begin
				remaining--;
				if (bcount == 0) begin
					held = b;
					bcount = 1;
				end else begin
					to_skip();
					push_event(KIND_TIMESIG, STATUS_META, 0, held, b, 0, 0, 0, 1'b0);
				end
			end
			P_TRIG_OLD, P_TRIG_NEW: begin
				remaining--;
				idx = bcount >> 2;
				if (idx > 2)
					idx = 2;
				if ((bcount & 3) == 0)
					words[idx] = 0;
				words[idx] = (words[idx] << 8) | b;
				bcount++;
				on = words[0];
				off = words[1];
				if (ph == P_TRIG_OLD && bcount >= 8) begin
					require(8, P_TRIG_OLD);
					push_event(KIND_TRIGGER, STATUS_META, 0, 0, 0, on, off - on, 0, 1'b0);
				end else if (ph == P_TRIG_NEW && bcount >= 12) begin
					require(12, P_TRIG_NEW);
					push_event(KIND_TRIGGER, STATUS_META, 0, 0, 0, on, off - on + 1, words[2],
						1'b0);
				end
			end
			default: ;
		endcase
	endtask

	task automatic status_in(input logic [7:0] b);
		logic [7:0] s;
		if (b[7])
			cur_status = b;
		s = cur_status;
		case (s[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: ph = P_D1_TWO;
			4'hC, 4'hD: ph = P_D1_ONE;
			default: begin
				if (s == STATUS_META)
					ph = P_META_TYPE;
				else if (s == STATUS_SYSEX) begin
					vacc = 0;
					ph = P_SYSEX_LEN;
				end else begin
					ph = P_HALT;
					push_event(KIND_ERROR, s, 0, 0, 0, 0, 0, 0, 1'b1);
					return;
				end
			end
		endcase
		if (!b[7])
			body(b);
	endtask

	task automatic predict_byte(input track_item_t it);
		if (it.tstart) begin
			run_time = 0;
			last_dt = 0;
			cur_status = 0;
			ptag = 0;
			remaining = 0;
			bcount = 0;
			to_delta();
		end
		if (ph == P_DELTA) begin
			vacc = (vacc << 7) | it.tbyte[6:0];
			if (!it.tbyte[7]) begin
				last_dt = vacc;
				run_time += last_dt;
				vacc = 0;
				ph = P_STATUS;
			end
		end else if (ph == P_STATUS)
			status_in(it.tbyte);
		else
			body(it.tbyte);
	endtask

	// Stimulus helpers.
	task automatic put(input logic [7:0] b, input bit s = 0);
		pending_bytes.push_back('{b, s});
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			put(w[i*8 +: 8]);
	endtask

	task automatic put_delta();
		case ($urandom_range(0, 5))
			0: put(8'h00);
			1: begin
				put(8'h80 | 8'($urandom_range(1, 127)));
				put(8'($urandom_range(0, 127)));
			end
			2: begin
				put(8'hFF);
				put(8'hFF);
				put(8'hFF);
				put(8'hFF);
				put(8'($urandom_range(0, 127)));
			end
			default: put(8'($urandom_range(0, 127)));
		endcase
	endtask

	task automatic put_prop(input logic [31:0] tag, input int body_len, input bit with_tag);
		put(8'h00);
		put(STATUS_META);
		put(META_PROP);
		put(8'(body_len + (with_tag ? 4 : 0)));
		if (with_tag)
			put_word(tag);
		repeat (body_len)
			put(8'($urandom));
	endtask

	task automatic put_random_event();
		logic [31:0] tag;
		int len;
		put_delta();
		case ($urandom_range(0, 15))
			0, 1, 2: begin
				put(8'h80 | 8'($urandom_range(0, 111)));
				put(8'($urandom_range(0, 127)));
				put($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 127)));
			end
			3: begin
				put(8'($urandom_range(0, 127)));
				put(8'($urandom_range(0, 127)));
			end
			4: begin
				put(8'hC0 | 8'($urandom_range(0, 31)));
				put(8'($urandom_range(0, 127)));
			end
			5: begin
				put(STATUS_META);
				put(META_NAME);
				len = $urandom_range(0, 6);
				put(8'(len));
				repeat (len)
					put(8'($urandom));
			end
			6: begin
				put(STATUS_META);
				put(META_SEQNUM);
				len = $urandom_range(0, 4);
				put(8'(len));
				repeat (len)
					put(8'($urandom));
			end
			7, 8, 9, 10: begin
				tag = p_tags[$urandom_range(0, 4)];
				put(STATUS_META);
				put(META_PROP);
				len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 30) : 4 + 12 *
					$urandom_range(0, 2) + $urandom_range(1, 9);
				put(8'(len));
				if (len > 4) begin
					put_word($urandom_range(0, 7) == 0 ? $urandom : tag);
					len -= 4;
				end
				repeat (len)
					put(8'($urandom));
			end
			11: begin
				put(STATUS_SYSEX);
				len = $urandom_range(0, 5);
				put(8'(len));
				repeat (len)
					put(8'($urandom));
			end
			12: begin
				put(STATUS_META);
				put(8'($urandom_range(0, 255)));
				len = $urandom_range(0, 3);
				put(8'(len));
				repeat (len)
					put(8'($urandom));
			end
			default: begin
				put(8'($urandom));
				put(8'($urandom));
			end
		endcase
	endtask

	task automatic put_track(input int n_events);
		put(8'($urandom_range(0, 127)), 1);
		put(ST_NOTE_ON | 8'($urandom_range(0, 15)));
		put(8'($urandom_range(0, 127)));
		put(8'($urandom_range(0, 127)));
		repeat (n_events)
			put_random_event();
		put(8'($urandom_range(0, 1)));
		put(STATUS_META);
		put(META_END);
		put(8'h00);
	endtask

	task automatic drain(input int extra);
		wait (pending_bytes.size() == 0 && !track_in.valid);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (extra)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FILE_PPQN: p_file = {16'd0, val[15:0]};
			CFG_TARGET_PPQN: p_target = {16'd0, val[15:0]};
			CFG_TAG_BUS: p_tags[0] = val;
			CFG_TAG_CHAN: p_tags[1] = val;
			CFG_TAG_TSIG: p_tags[2] = val;
			CFG_TAG_TRIG_O: p_tags[3] = val;
			default: p_tags[4] = val;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FILE_PPQN;
		cfg_data = '0;
		stim_done = 1'b0;
		pause_sender = 1'b0;
		hold_off = 0;
		p_file = 192;
		p_target = 192;
		p_tags = '{32'h24240001, 32'h24240002, 32'h24240006, 32'h24240004, 32'h24240008};
		ph = P_DELTA;
		cur_status = 0;
		vacc = 0;
		last_dt = 0;
		run_time = 0;
		meta_t = 0;
		remaining = 0;
		ptag = 0;
		words = '{0, 0, 0};
		bcount = 0;
		held = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: error cases, three tracks that each start with an invalid status byte.
		put(8'h00, 1);
		put(8'h45);
		put(8'h81);
		put(8'h90);
		put(8'h3C);
		put(8'h00);
		put(8'h00);
		put(8'h7F);
		put(8'hFF);
		put(8'h00);
		put(8'hDF);
		put(8'h7F);
		put_prop(32'h24240001, 1, 0);
		put_prop(32'h24240002, 1, 1);
		put_prop(32'h24240006, 2, 1);
		put_prop(32'h24240004, 17, 1);
		put_prop(32'h24240008, 12, 1);
		put(8'h00);
		put(8'hFF);
		put(META_END);
		put(8'h00);
		put(8'h00, 1);
		put(8'h12);
		put(8'h00, 1);
		put(8'hF5);
		drain(40);

		// Full range rates with a long name and a delayed receiver.
		write_reg(CFG_FILE_PPQN, 32'h0000FFFF);
		write_reg(CFG_TARGET_PPQN, 32'h00000001);
		put(8'h7F, 1);
		put(STATUS_META);
		put(META_NAME);
		put(8'h82);
		put(8'h2C);
		repeat (300)
			put(8'($urandom));
		put(8'h00);
		put(8'hFF);
		put(META_END);
		put(8'h00);
		hold_off = 400;
		drain(40);

		write_reg(CFG_FILE_PPQN, 32'h00000001);
		write_reg(CFG_TARGET_PPQN, 32'h0000FFFF);
		for (int k = 2; k <= 6; k++)
			write_reg(3'(k), $urandom_range(0, 1) ? $urandom : 32'h24240003 + k);
		put_track(20);
		drain(40);

		write_reg(CFG_FILE_PPQN, 32'h00000000);
		write_reg(CFG_TAG_BUS, 32'h0);
		write_reg(CFG_TAG_CHAN, 32'h0);
		put_track(10);
		drain(40);

		write_reg(CFG_FILE_PPQN, 32'd96);
		write_reg(CFG_TARGET_PPQN, 32'd480);
		write_reg(CFG_TAG_BUS, 32'h24240001);
		write_reg(CFG_TAG_CHAN, 32'h24240002);
		write_reg(CFG_TAG_TSIG, 32'h24240006);
		write_reg(CFG_TAG_TRIG_O, 32'h24240004);
		write_reg(CFG_TAG_TRIG_N, 32'h24240008);
		while (pending_bytes.size() < 600)
			put_track($urandom_range(3, 25));
		drain(40);
		stim_done = 1'b1;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_in.valid <= 1'b0;
			track_in.track_byte <= '0;
			track_in.track_start <= 1'b0;
			send_wait <= 0;
		end else begin
			byte_accepted = track_in.valid && track_in.ready;
			if (byte_accepted) begin
				predict_byte('{track_in.track_byte, track_in.track_start});
				if ($urandom_range(0, 199) == 0)
					pause_sender = 1'b1;
			end
			if (pause_sender && expected_events.size() == 0 && (track_in.valid == 0
				|| byte_accepted))
				pause_sender = 1'b0;
			if (track_in.valid && !byte_accepted) begin
			end else if (send_wait > 0 || pause_sender || pending_bytes.size() == 0) begin
				track_in.valid <= 1'b0;
				if (send_wait > 0)
					send_wait <= send_wait - 1;
			end else begin
				track_in.valid <= 1'b1;
				{track_in.track_byte, track_in.track_start} <= pending_bytes.pop_front();
				send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end
		end
	end

	// Monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		parsed_event_t got, want;
		if (!arst_n) begin
			event_out.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (event_out.valid && event_out.ready) begin
				got = '{event_out.kind, event_out.timestamp, event_out.status_code,
					event_out.channel_number, event_out.data_first, event_out.data_second,
					event_out.value_a, event_out.value_b, event_out.value_c,
					event_out.last_of_track};
				if (expected_events.size() == 0) begin
					$error("unexpected event kind %0d", got.kind);
					errors++;
				end else begin
					want = expected_events.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind expected %0d got %0d", want.kind, got.kind); errors++;
					end
					if (got.ts !== want.ts) begin
						$error("timestamp expected %h got %h", want.ts, got.ts); errors++;
					end
					if (got.st !== want.st) begin
						$error("status_code expected %h got %h", want.st, got.st); errors++;
					end
					if (got.ch !== want.ch) begin
						$error("channel_number expected %h got %h", want.ch, got.ch); errors++;
					end
					if (got.d1 !== want.d1) begin
						$error("data_first expected %h got %h", want.d1, got.d1); errors++;
					end
					if (got.d2 !== want.d2) begin
						$error("data_second expected %h got %h", want.d2, got.d2); errors++;
					end
					if (got.a !== want.a) begin
						$error("value_a expected %h got %h", want.a, got.a); errors++;
					end
					if (got.b !== want.b) begin
						$error("value_b expected %h got %h", want.b, got.b); errors++;
					end
					if (got.c !== want.c) begin
						$error("value_c expected %h got %h", want.c, got.c); errors++;
					end
					if (got.last !== want.last) begin
						$error("last_of_track expected %b got %b", want.last, got.last);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				event_out.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (recv_wait > 0) begin
				event_out.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else if (event_out.valid && event_out.ready) begin
				event_out.ready <= 1'b0;
				recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end else
				event_out.ready <= 1'b1;
		end
	end

	initial begin
		errors = 0;
		cycle_count = 0;
		while (!stim_done && cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		if (!stim_done)
			$display("tb_top: FAIL");
		else if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
